// ----- sv/ddpf_pkg.sv -----
// ddpf_pkg: shared types, constants and saturating add for the diff drive controller
// no dependencies

package ddpf_pkg;

   localparam int ACC_W  = 62;
   localparam int BATT_W = 15;
   localparam int CFG_IDX_W = 4;

   localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(64'sh1000_0000_0000_0000);
   localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI;

   localparam int BIAS_RIGHT = 330;
   localparam int BIAS_LEFT  = 370;

   localparam logic [CFG_IDX_W-1:0] CFG_SPEED_P = 4'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_SPEED_I = 4'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_SPEED_D = 4'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_YAW_P   = 4'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_YAW_I   = 4'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_YAW_D   = 4'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_ACC_FF  = 4'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_BIAS_FF = 4'd7;

   typedef logic signed [ACC_W-1:0] acc_type;

   function automatic acc_type sat_add(input acc_type x, input acc_type y);
      logic signed [ACC_W:0] s;
      s = $signed({x[ACC_W-1], x}) + $signed({y[ACC_W-1], y});
      if (s > SAT_HI) begin
         s = SAT_HI;
      end else if (s < SAT_LO) begin
         s = SAT_LO;
      end
      return ACC_W'(s);
   endfunction

endpackage

// ----- sv/diff_drive_pid_feedforward_core.sv -----
// diff_drive_pid_feedforward_core: speed and yaw rate PID with feedforward, differential drive
// depends on ddpf_pkg and ddpf_mul
//
// One request produces one response. Eleven products run one after another through a
// single 32 x 16 bit multiplier, and each motor duty then takes one more product and an
// 11 step (at the default DUTY_MAX) restoring division by the battery level; both are
// skipped when that drive saturates or the battery reads zero. The block takes no new request
// while it works; a finished response may wait on rsp_stall while the next request is
// accepted. Gains are to be written through the csr port only while the block is idle;
// the block itself does not enforce this. Writes to indexes above 7 are dropped.

module diff_drive_pid_feedforward_core
   import ddpf_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48,
   parameter int DUTY_MAX       = 1499
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_speed_measured,
   input  logic signed [31:0]             req_speed_target,
   input  logic signed [31:0]             req_accel_target,
   input  logic signed [31:0]             req_yaw_rate_measured,
   input  logic signed [31:0]             req_yaw_rate_target,
   input  logic signed [31:0]             req_yaw_accel,
   input  logic [BATT_W-1:0]              req_battery_level,
   input  logic                           req_clear_speed_state,
   input  logic                           req_clear_yaw_state,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_right_reverse,
   output logic [$clog2(DUTY_MAX+1)-1:0]  rsp_right_duty,
   output logic                           rsp_left_reverse,
   output logic [$clog2(DUTY_MAX+1)-1:0]  rsp_left_duty,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CFG_IDX_W-1:0]           csr_index,
   input  logic [31:0]                    csr_data
);

   localparam int IW   = INTEGRAL_WIDTH;
   localparam int QW   = $clog2(DUTY_MAX + 1);
   localparam int NW   = BATT_W + QW;
   localparam int BW0  = (IW > 34) ? IW : 34;
   localparam int B_W  = (BW0 > FRAC_BITS + 17) ? BW0 : FRAC_BITS + 17;
   localparam int DCW  = $clog2(QW);
   localparam int C02  = ((2 ** (FRAC_BITS + 1)) + 50) / 100;
   localparam int C25  = (2 ** FRAC_BITS) / 4;
   localparam logic signed [B_W-1:0] BIAS_R_Q = B_W'(BIAS_RIGHT) << FRAC_BITS;
   localparam logic signed [B_W-1:0] BIAS_L_Q = B_W'(BIAS_LEFT) << FRAC_BITS;
   localparam logic signed [IW:0] IMAX = (IW+1)'((65'sd1 <<< (IW - 1)) - 65'sd1);
   localparam logic signed [IW:0] IMIN = -IMAX - (IW+1)'(1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ERR   = 4'd1;
   localparam logic [3:0] ST_INT   = 4'd2;
   localparam logic [3:0] ST_STEP  = 4'd3;
   localparam logic [3:0] ST_WAIT  = 4'd4;
   localparam logic [3:0] ST_MIX   = 4'd5;
   localparam logic [3:0] ST_DRV   = 4'd6;
   localparam logic [3:0] ST_DMUL  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_STORE = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   localparam logic [3:0] LAST_STEP = 4'd10;

   logic [3:0]              state_ff, step_ff;
   logic signed [31:0]      cfg_ff [8];
   logic signed [31:0]      sp_m_ff, sp_t_ff, acc_t_ff, yr_m_ff, yr_t_ff, ya_ff;
   logic [BATT_W-1:0]       batt_ff;
   logic                    clr_s_ff, clr_y_ff;
   logic signed [31:0]      err_s_ff, err_y_ff, last_s_ff, last_y_ff;
   logic signed [32:0]      d_s_ff, d_y_ff;
   logic signed [IW-1:0]    int_s_ff, int_y_ff;
   acc_type                 acc_ff, base_ff, ur_ff, ul_ff;
   logic                    motor_ff;
   logic [BATT_W-1:0]       rem_ff;
   logic [QW-1:0]           dq_ff;
   logic [DCW-1:0]          dcnt_ff;
   logic                    r_rev_ff, l_rev_ff;
   logic [QW-1:0]           r_duty_ff, l_duty_ff;
   logic                    rsp_valid_ff, o_r_rev_ff, o_l_rev_ff;
   logic [QW-1:0]           o_r_duty_ff, o_l_duty_ff;

   logic                    mul_start, mul_done;
   logic signed [31:0]      mul_a;
   logic signed [B_W-1:0]   mul_b;
   acc_type                 mul_p;

   logic signed [32:0]      dif_s, dif_y;
   logic signed [IW:0]      isum_s, isum_y;
   acc_type                 u_sel;
   logic [ACC_W-1:0]        mag;
   logic [BATT_W+FRAC_BITS-1:0] bq;
   logic [BATT_W:0]         trial;
   logic                    ge;
   logic                    out_free;

   function automatic logic signed [31:0] clamp32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [IW-1:0] clamp_i(input logic signed [IW:0] v);
      if (v > IMAX) begin
         return IW'(IMAX);
      end else if (v < IMIN) begin
         return IW'(IMIN);
      end
      return IW'(v);
   endfunction

   ddpf_mul #(
      .FRAC_BITS (FRAC_BITS),
      .B_W       (B_W)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   assign dif_s  = {sp_m_ff[31], sp_m_ff} - {sp_t_ff[31], sp_t_ff};
   assign dif_y  = {yr_m_ff[31], yr_m_ff} - {yr_t_ff[31], yr_t_ff};
   assign isum_s = (IW+1)'(int_s_ff) + (IW+1)'(err_s_ff);
   assign isum_y = (IW+1)'(int_y_ff) + (IW+1)'(err_y_ff);

   assign u_sel = motor_ff ? ul_ff : ur_ff;
   assign mag   = u_sel[ACC_W-1] ? ACC_W'(-u_sel) : ACC_W'(u_sel);
   assign bq    = {batt_ff, FRAC_BITS'(0)};
   assign trial = {rem_ff, dq_ff[QW-1]};
   assign ge    = trial >= {1'b0, batt_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mul_start = 1'b0;
      mul_a     = cfg_ff[CFG_SPEED_P[2:0]];
      mul_b     = B_W'(err_s_ff);
      if (state_ff == ST_STEP) begin
         mul_start = 1'b1;
         case (step_ff)
            4'd0: begin mul_a = cfg_ff[CFG_SPEED_P[2:0]]; mul_b = B_W'(err_s_ff); end
            4'd1: begin mul_a = cfg_ff[CFG_SPEED_I[2:0]]; mul_b = B_W'(int_s_ff); end
            4'd2: begin mul_a = cfg_ff[CFG_SPEED_D[2:0]]; mul_b = B_W'(d_s_ff); end
            4'd3: begin mul_a = cfg_ff[CFG_ACC_FF[2:0]];  mul_b = B_W'(acc_t_ff); end
            4'd4: begin mul_a = cfg_ff[CFG_BIAS_FF[2:0]]; mul_b = BIAS_R_Q; end
            4'd5: begin mul_a = cfg_ff[CFG_BIAS_FF[2:0]]; mul_b = BIAS_L_Q; end
            4'd6: begin mul_a = cfg_ff[CFG_YAW_P[2:0]];   mul_b = B_W'(err_y_ff); end
            4'd7: begin mul_a = cfg_ff[CFG_YAW_I[2:0]];   mul_b = B_W'(int_y_ff); end
            4'd8: begin mul_a = cfg_ff[CFG_YAW_D[2:0]];   mul_b = B_W'(d_y_ff); end
            4'd9: begin mul_a = 32'(C02);                 mul_b = B_W'(ya_ff); end
            default: begin mul_a = 32'(C25);              mul_b = B_W'(yr_m_ff); end
         endcase
      end else if (state_ff == ST_DRV && batt_ff != '0 && mag < ACC_W'(bq)) begin
         mul_start = 1'b1;
         mul_a     = 32'(DUTY_MAX);
         mul_b     = B_W'(mag);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         motor_ff     <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         int_s_ff     <= '0;
         int_y_ff     <= '0;
         last_s_ff    <= '0;
         last_y_ff    <= '0;
         for (int i = 0; i < 8; i++) begin
            cfg_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_index < CFG_IDX_W'(8)) begin
            cfg_ff[csr_index[2:0]] <= csr_data;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_ERR;
               end
            end
            ST_ERR: begin
               if (clr_s_ff) begin
                  int_s_ff  <= '0;
                  last_s_ff <= '0;
               end
               if (clr_y_ff) begin
                  int_y_ff  <= '0;
                  last_y_ff <= '0;
               end
               state_ff <= ST_INT;
            end
            ST_INT: begin
               int_s_ff  <= clamp_i(isum_s);
               int_y_ff  <= clamp_i(isum_y);
               last_s_ff <= err_s_ff;
               last_y_ff <= err_y_ff;
               step_ff   <= '0;
               state_ff  <= ST_STEP;
            end
            ST_STEP: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mul_done) begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= (step_ff == LAST_STEP) ? ST_MIX : ST_STEP;
               end
            end
            ST_MIX: begin
               motor_ff <= 1'b0;
               state_ff <= ST_DRV;
            end
            ST_DRV: begin
               if (mul_start) begin
                  state_ff <= ST_DMUL;
               end else begin
                  state_ff <= ST_STORE;
               end
            end
            ST_DMUL: begin
               if (mul_done) begin
                  dcnt_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(QW - 1)) begin
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               motor_ff <= 1'b1;
               state_ff <= motor_ff ? ST_OUT : ST_DRV;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sp_m_ff  <= req_speed_measured;
            sp_t_ff  <= req_speed_target;
            acc_t_ff <= req_accel_target;
            yr_m_ff  <= req_yaw_rate_measured;
            yr_t_ff  <= req_yaw_rate_target;
            ya_ff    <= req_yaw_accel;
            batt_ff  <= req_battery_level;
            clr_s_ff <= req_clear_speed_state;
            clr_y_ff <= req_clear_yaw_state;
         end
         ST_ERR: begin
            err_s_ff <= clamp32(dif_s);
            err_y_ff <= clamp32(dif_y);
         end
         ST_INT: begin
            d_s_ff <= {err_s_ff[31], err_s_ff} - {last_s_ff[31], last_s_ff};
            d_y_ff <= {err_y_ff[31], err_y_ff} - {last_y_ff[31], last_y_ff};
         end
         ST_WAIT: begin
            if (mul_done) begin
               case (step_ff)
                  4'd0, 4'd6: acc_ff <= mul_p;
                  4'd1, 4'd2, 4'd7, 4'd8: acc_ff <= sat_add(acc_ff, mul_p);
                  4'd3: base_ff <= sat_add(-acc_ff, mul_p);
                  4'd4: ur_ff <= sat_add(base_ff, mul_p);
                  4'd5: ul_ff <= sat_add(base_ff, mul_p);
                  default: acc_ff <= sat_add(acc_ff, -mul_p);
               endcase
            end
         end
         ST_MIX: begin
            ur_ff <= sat_add(ur_ff, -acc_ff);
            ul_ff <= sat_add(ul_ff, acc_ff);
         end
         ST_DRV: begin
            if (batt_ff == '0) begin
               dq_ff <= '0;
            end else begin
               dq_ff <= QW'(DUTY_MAX);
            end
         end
         ST_DMUL: begin
            rem_ff <= mul_p[NW-1:QW];
            dq_ff  <= mul_p[QW-1:0];
         end
         ST_DIV: begin
            rem_ff <= ge ? BATT_W'(trial - {1'b0, batt_ff}) : BATT_W'(trial);
            dq_ff  <= {dq_ff[QW-2:0], ge};
         end
         ST_STORE: begin
            if (motor_ff) begin
               l_rev_ff  <= u_sel[ACC_W-1] || (dq_ff == '0);
               l_duty_ff <= dq_ff;
            end else begin
               r_rev_ff  <= u_sel[ACC_W-1] || (dq_ff == '0);
               r_duty_ff <= dq_ff;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               o_r_rev_ff  <= r_rev_ff;
               o_r_duty_ff <= r_duty_ff;
               o_l_rev_ff  <= l_rev_ff;
               o_l_duty_ff <= l_duty_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_reverse = o_r_rev_ff;
   assign rsp_right_duty    = o_r_duty_ff;
   assign rsp_left_reverse  = o_l_rev_ff;
   assign rsp_left_duty     = o_l_duty_ff;

   a_mul_owned: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_WAIT || state_ff == ST_DMUL))
      else $error("multiplier result with no consumer");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ERR))
      else $error("accepted request did not start the sequence");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_duty <= QW'(DUTY_MAX) && rsp_left_duty <= QW'(DUTY_MAX)))
      else $error("duty above limit");

   a_zero_reverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_right_duty != '0 || rsp_right_reverse)
                     && (rsp_left_duty != '0 || rsp_left_reverse)))
      else $error("zero duty without reverse flag");

endmodule

// ----- sv/ddpf_mul.sv -----
// ddpf_mul: sequential signed fixed point multiplier, 32 x 16 bits per cycle
// result floored by FRAC_BITS and saturated; depends on ddpf_pkg

module ddpf_mul
   import ddpf_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int B_W       = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      a,
   input  logic signed [B_W-1:0]   b,
   output logic                    done,
   output logic signed [ACC_W-1:0] p
);

   localparam int NDIG   = (B_W + 15) / 16;
   localparam int UB_W   = NDIG * 16;
   localparam int PROD_W = 32 + UB_W;
   localparam int CW     = $clog2(NDIG + 1);

   logic                     busy_ff, fin_ff, done_ff, neg_ff;
   logic [CW-1:0]            cnt_ff;
   logic [31:0]              ua_ff;
   logic [UB_W-1:0]          ub_ff;
   logic [PROD_W-1:0]        acc_ff;
   logic signed [ACC_W-1:0]  p_ff;

   logic [31:0]              ua_abs;
   logic [B_W-1:0]           ub_abs;
   logic [47:0]              part;
   logic [PROD_W-1:0]        acc_in;
   logic signed [PROD_W:0]   sp, q, qc;

   assign ua_abs = a[31] ? (~a + 32'd1) : a;
   assign ub_abs = b[B_W-1] ? (~b + B_W'(1)) : b;
   assign part   = ua_ff * ub_ff[UB_W-1 -: 16];
   assign acc_in = {acc_ff[PROD_W-17:0], 16'd0} + PROD_W'(part);

   always_comb begin
      sp = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      q  = sp >>> FRAC_BITS;
      if (q > SAT_HI) begin
         qc = SAT_HI;
      end else if (q < SAT_LO) begin
         qc = SAT_LO;
      end else begin
         qc = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(NDIG - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= ua_abs;
         ub_ff  <= UB_W'(ub_abs);
         neg_ff <= a[31] ^ b[B_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         ub_ff  <= {ub_ff[UB_W-17:0], 16'd0};
      end
      if (fin_ff) begin
         p_ff <= ACC_W'(qc);
      end
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule
